// ===== src/kap_pkg.sv =====
// Shared types, codes and helpers for the keep-alive ping supervisor.
`timescale 1ns / 1ps
package kap_pkg;

	localparam int TIMER_BITS = 26;
	localparam int CFG_BITS   = 26;
	localparam int RETRY_BITS = 8;
	localparam int CMD_BITS   = 3;
	localparam int STAT_BITS  = 2;
	localparam int IDX_BITS   = 2;

	localparam logic [31:0] TIMER_MAX32 = 32'((64'd1 << TIMER_BITS) - 64'd1);

	// event codes
	localparam logic [CMD_BITS-1:0] CMD_TICK     = 3'd0;
	localparam logic [CMD_BITS-1:0] CMD_START    = 3'd1;
	localparam logic [CMD_BITS-1:0] CMD_SENT     = 3'd2;
	localparam logic [CMD_BITS-1:0] CMD_PINGREQ  = 3'd3;
	localparam logic [CMD_BITS-1:0] CMD_PINGRESP = 3'd4;
	localparam logic [CMD_BITS-1:0] CMD_OTHER    = 3'd5;
	localparam logic [CMD_BITS-1:0] CMD_FORCE    = 3'd6;

	// link status codes
	localparam logic [STAT_BITS-1:0] ST_ASLEEP       = 2'd1;
	localparam logic [STAT_BITS-1:0] ST_DISCONNECTED = 2'd2;

	// configuration register indexes
	localparam logic [IDX_BITS-1:0] CFG_KEEP_ALIVE   = 2'd0;
	localparam logic [IDX_BITS-1:0] CFG_RETRY_PERIOD = 2'd1;
	localparam logic [IDX_BITS-1:0] CFG_RETRY_LIMIT  = 2'd2;

	localparam logic [CFG_BITS-1:0]   KEEP_ALIVE_RST   = 26'd0;
	localparam logic [CFG_BITS-1:0]   RETRY_PERIOD_RST = 26'd10000;
	localparam logic [RETRY_BITS-1:0] RETRY_LIMIT_RST  = 8'd3;

	typedef struct packed {
		logic [CMD_BITS-1:0]  command;
		logic [STAT_BITS-1:0] conn_status;
	} kap_in_t;

	typedef struct packed {
		logic send_pingreq;
		logic with_client_id;
		logic send_pingresp;
		logic gateway_lost;
	} kap_out_t;

	// per-timer control for one transaction
	typedef struct packed {
		logic tick;
		logic stop;
		logic load;
	} kap_tmr_ctl_t;

	// per-timer status seen by the controller
	typedef struct packed {
		logic active;
		logic expiring;
	} kap_tmr_stat_t;

	typedef struct packed {
		kap_tmr_ctl_t send_idle;
		kap_tmr_ctl_t recv_idle;
		kap_tmr_ctl_t resp_wait;
	} kap_ctl_t;

	// clamp a configured period to the timer range
	function automatic logic [TIMER_BITS-1:0] sat_period(input logic [CFG_BITS-1:0] p);
		logic [31:0] p32;
		p32 = 32'(p);
		if (p32 > TIMER_MAX32) begin
			return TIMER_BITS'(TIMER_MAX32);
		end
		return TIMER_BITS'(p32);
	endfunction

endpackage

// ===== src/kap_timer.sv =====
// One countdown timer with active flag, ticked and reloaded per transaction.
`timescale 1ns / 1ps
module kap_timer
	import kap_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  kap_tmr_ctl_t          ctl,
	input  logic [TIMER_BITS-1:0] period,
	output kap_tmr_stat_t         stat
);

	logic [TIMER_BITS-1:0] count_q, count_d;
	logic                  active_q, active_d;
	logic                  expiring;

	assign expiring = active_q && (count_q[TIMER_BITS-1:1] == '0);
	assign stat.active   = active_q;
	assign stat.expiring = expiring;

	always_comb begin
		count_d  = count_q;
		active_d = active_q;
		// tick first, then stop or reload override
		if (ctl.tick && active_q) begin
			if (expiring) begin
				count_d  = '0;
				active_d = 1'b0;
			end else begin
				count_d = count_q - TIMER_BITS'(1);
			end
		end
		if (ctl.stop) begin
			active_d = 1'b0;
		end
		if (ctl.load) begin
			count_d  = period;
			active_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			active_q <= 1'b0;
		end else if (en) begin
			count_q  <= count_d;
			active_q <= active_d;
		end
	end

endmodule

// ===== src/kap_ctrl.sv =====
// Event decode: timer controls, retry update and result for one event.
`timescale 1ns / 1ps
module kap_ctrl
	import kap_pkg::*;
(
	input  kap_in_t               item,
	input  logic                  ka_nz,
	input  logic [RETRY_BITS-1:0] retry_limit,
	input  logic [RETRY_BITS-1:0] retries_q,
	input  kap_tmr_stat_t         send_stat,
	input  kap_tmr_stat_t         recv_stat,
	input  kap_tmr_stat_t         resp_stat,
	output kap_ctl_t              ctl,
	output logic [RETRY_BITS-1:0] retries_d,
	output kap_out_t              result
);

	logic tick, f_send, f_recv, f_resp;
	logic lost, retry, resp_after, ping_idle, ping;
	logic asleep;

	assign asleep = (item.conn_status == ST_ASLEEP);
	assign tick   = (item.command == CMD_TICK);
	assign f_send = tick && send_stat.expiring;
	assign f_recv = tick && recv_stat.expiring;
	assign f_resp = tick && resp_stat.expiring;

	// response-wait expiry is handled before idle expiries
	assign lost       = f_resp && (retries_q == '0);
	assign retry      = f_resp && (retries_q != '0);
	assign resp_after = (resp_stat.active && !f_resp) || retry;
	assign ping_idle  = !lost && (f_send || f_recv) && !resp_after;

	always_comb begin
		ctl       = '0;
		retries_d = retries_q;
		result    = '0;
		ping      = 1'b0;
		case (item.command)
			CMD_TICK: begin
				ctl.send_idle.tick = 1'b1;
				ctl.recv_idle.tick = 1'b1;
				ctl.resp_wait.tick = 1'b1;
				ctl.send_idle.stop = lost;
				ctl.recv_idle.stop = lost;
				ctl.resp_wait.stop = lost;
				result.gateway_lost = lost;
				if (retry) begin
					retries_d = retries_q - RETRY_BITS'(1);
				end
				ping = retry || ping_idle;
			end
			CMD_START: begin
				retries_d          = retry_limit;
				ctl.recv_idle.stop = 1'b1;
				ctl.resp_wait.stop = 1'b1;
				ctl.send_idle.load = ka_nz;
			end
			CMD_SENT: begin
				ctl.send_idle.load = ka_nz;
			end
			CMD_PINGREQ: begin
				if (item.conn_status != ST_DISCONNECTED) begin
					result.send_pingresp = 1'b1;
					ctl.send_idle.load   = ka_nz;
					ctl.recv_idle.load   = ka_nz;
				end
			end
			CMD_PINGRESP: begin
				ctl.resp_wait.stop = 1'b1;
				retries_d          = retry_limit;
				ctl.recv_idle.load = ka_nz;
			end
			CMD_OTHER: begin
				ctl.resp_wait.load = asleep && resp_stat.active;
				ctl.recv_idle.load = ka_nz;
			end
			CMD_FORCE: begin
				ping = !resp_stat.active;
			end
			default: begin
				// unused event code: no effect
			end
		endcase
		// a ping restarts send-idle (when keep-alive is nonzero) and opens a response wait
		if (ping) begin
			result.send_pingreq   = 1'b1;
			result.with_client_id = asleep;
			ctl.send_idle.load    = ka_nz;
			ctl.resp_wait.load    = 1'b1;
		end
	end

endmodule

// ===== src/keepalive_ping_supervisor_core.sv =====
// Top level of the keep-alive ping supervisor: channels, registers, timers.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one event per transaction:
//   a 1 ms tick, start, message sent, received PINGREQ/PINGRESP/other, or a
//   forced ping, together with the present link status.
//   Output channel (out_valid/out_ready/out_data) returns exactly one result
//   per event: send PINGREQ (with client id when asleep), send PINGRESP, and
//   the gateway-lost flag.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
//   keep-alive period, retry period and retry limit; it is always ready.
//   Write it only while no event is in flight.
// Timing:
//   An accepted event is held in the input register until the result register
//   is free or draining; then the decode logic updates the timers and retry
//   count and loads the result register, which drives the output channel.
//   One event per cycle is sustained while out_ready stays high, set by the
//   timer and retry update between the input and result registers.
// Reset: clears all timers, the retry count and both pipeline valids; the
//   configuration registers return to 0 ms, 10000 ms and 3 retries.
// Stall: while out_ready is low the result holds, the input register holds
//   its event, and in_ready drops once the input register is occupied.
module keepalive_ping_supervisor_core
	import kap_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  kap_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output kap_out_t             out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_BITS-1:0]  cfg_data
);

	// configuration
	logic [CFG_BITS-1:0]   keep_alive_q;
	logic [CFG_BITS-1:0]   retry_period_q;
	logic [RETRY_BITS-1:0] retry_limit_q;

	// input stage
	logic    valid_s1;
	kap_in_t item_s1;

	// result stage
	logic     valid_s2;
	kap_out_t result_s2;

	logic [RETRY_BITS-1:0] retries_q, retries_d;
	logic                  advance;
	kap_ctl_t              ctl;
	kap_out_t              result;
	kap_tmr_stat_t         send_stat, recv_stat, resp_stat;
	logic [TIMER_BITS-1:0] idle_period, resp_period;

	assign cfg_ready = 1'b1;

	// process the held event whenever the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	assign idle_period = sat_period(keep_alive_q);
	assign resp_period = sat_period(retry_period_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_alive_q   <= KEEP_ALIVE_RST;
			retry_period_q <= RETRY_PERIOD_RST;
			retry_limit_q  <= RETRY_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KEEP_ALIVE:   keep_alive_q   <= cfg_data;
				CFG_RETRY_PERIOD: retry_period_q <= cfg_data;
				CFG_RETRY_LIMIT:  retry_limit_q  <= cfg_data[RETRY_BITS-1:0];
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	// input register: capture a transaction, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	kap_ctrl u_ctrl (
		.item        (item_s1),
		.ka_nz       (keep_alive_q != '0),
		.retry_limit (retry_limit_q),
		.retries_q   (retries_q),
		.send_stat   (send_stat),
		.recv_stat   (recv_stat),
		.resp_stat   (resp_stat),
		.ctl         (ctl),
		.retries_d   (retries_d),
		.result      (result)
	);

	kap_timer u_send_idle (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.ctl    (ctl.send_idle),
		.period (idle_period),
		.stat   (send_stat)
	);

	kap_timer u_recv_idle (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.ctl    (ctl.recv_idle),
		.period (idle_period),
		.stat   (recv_stat)
	);

	kap_timer u_resp_wait (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.ctl    (ctl.resp_wait),
		.period (resp_period),
		.stat   (resp_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retries_q <= '0;
		end else if (advance) begin
			retries_q <= retries_d;
		end
	end

	// result register: load on advance, clear valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	// gateway loss stops every timer
	a_lost_stops_timers: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && result.gateway_lost) |=>
		(!send_stat.active && !recv_stat.active && !resp_stat.active))
		else $error("timer still running after gateway loss");

	// a ping always leaves a response wait open
	a_ping_opens_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && result.send_pingreq) |=> resp_stat.active)
		else $error("ping sent without response wait");

	// client id only rides on a ping, and loss never comes with a ping
	a_result_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((!result_s2.with_client_id || result_s2.send_pingreq) &&
		!(result_s2.gateway_lost && result_s2.send_pingreq)))
		else $error("inconsistent result flags");

endmodule
